/* sv/tcfc_pkg.sv */
// Package for the tick clock frequency calibrator.
// Holds widths, register indexes, reset values and the divider handshake types.
// Depends on nothing; every other file of the block uses it.
package tcfc_pkg;

   localparam int CYC_W       = 64;
   localparam int DIVISOR_W   = 64;
   localparam int DIVIDEND_W  = 74;   // 64-bit cycles times 1000 fits in 74 bits
   localparam int STEP_W      = 7;
   localparam int STEPS_CPT   = 64;
   localparam int STEPS_FREQ  = 74;
   localparam int CPT_SHIFT   = DIVIDEND_W - STEPS_CPT;

   // x * 1000 = (x << 10) - (x << 4) - (x << 3)
   localparam int MUL_SH_A = 10;
   localparam int MUL_SH_B = 4;
   localparam int MUL_SH_C = 3;

   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 16;
   localparam int WARMUP_W   = 8;
   localparam int WINDOW_W   = 16;
   localparam int PERIOD_W   = 10;

   localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

   localparam logic [WARMUP_W-1:0] WARMUP_RESET = 8'd4;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd64;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd55;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      logic [STEP_W-1:0]     steps;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/tcfc_if.sv */
// Valid/ready channel interfaces of the tick clock frequency calibrator.
// Depends on tcfc_pkg for the cycle counter width.
interface tcfc_req_if;
   logic                       valid;
   logic                       ready;
   logic [tcfc_pkg::CYC_W-1:0] stamp;

   modport source (output valid, output stamp, input ready);
   modport sink   (input valid, input stamp, output ready);
endinterface

interface tcfc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       calibrated;
   logic [tcfc_pkg::CYC_W-1:0] cycles_per_tick;
   logic [tcfc_pkg::CYC_W-1:0] frequency_hz;

   modport source (output valid, output calibrated, output cycles_per_tick,
                   output frequency_hz, input ready);
   modport sink   (input valid, input calibrated, input cycles_per_tick,
                   input frequency_hz, output ready);
endinterface

/* sv/tcfc_div.sv */
// Shared bit-serial restoring divider: one quotient bit per cycle.
// Depends on tcfc_pkg for widths and the request/response structs.
module tcfc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tcfc_pkg::div_req_type req_i,
   output tcfc_pkg::div_rsp_type rsp_o
);

   localparam int NW = tcfc_pkg::DIVIDEND_W;
   localparam int DW = tcfc_pkg::DIVISOR_W;
   localparam int SW = tcfc_pkg::STEP_W;

   logic [NW-1:0] work_ff, work_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;
   logic          qbit;

   always_comb begin
      rem_sh     = {rem_ff, work_ff[NW-1]};
      diff       = rem_sh - {1'b0, divisor_ff};
      qbit       = ~diff[DW];
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req_i.start) begin
         work_in    = req_i.dividend;
         rem_in     = '0;
         divisor_in = req_i.divisor;
         cnt_in     = req_i.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit left
         work_in = {work_ff[NW-2:0], qbit};
         rem_in  = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
         cnt_in  = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp_o.done     = done_ff;
   assign rsp_o.quotient = work_ff;

endmodule

/* sv/tick_clock_frequency_calibrator.sv */
// Top level of the tick clock frequency calibrator: sequencer, state and registers.
// Depends on tcfc_pkg, the channel interfaces in tcfc_if and the divider tcfc_div.
//
// Usage: every beat on req_if is one reference tick carrying the free-running
//   cycle counter stamp. Every accepted tick yields exactly one beat on rsp_if with
//   calibrated, cycles_per_tick and frequency_hz as they stand after that tick.
//   The block counts ticks, skips warmup_ticks of them, records a start point,
//   and once window_ticks ticks have passed divides elapsed cycles by elapsed
//   ticks, then scales by 1000 / tick_period_ms with saturation. After that it
//   holds the latched values.
// Throughput: one tick at a time, req_if.ready high only in the
//   idle state. A tick that only counts, records or is rejected before the
//   divide goes from EVAL straight to EMIT; a zero cycles-per-tick quotient
//   ends after the first divide. The measuring tick runs the shared serial
//   divider twice (64 quotient bits, then 74), one quotient bit per cycle.
// Stall: the response sits in an output register, so the next tick can be
//   accepted while rsp_if waits; a finished result holds until the slot frees.
// Reset: synchronous, active high. Clears counters, start point, latched
//   values and calibrated, and returns the registers to 4 / 64 / 55.
// Registers: csr_we writes csr_wdata into warmup_ticks (0), window_ticks (1)
//   or tick_period_ms (2); other indexes are dropped. Write while idle.
module tick_clock_frequency_calibrator #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tcfc_req_if.sink                        req_if,
   tcfc_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [tcfc_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [tcfc_pkg::CFG_DATA_W-1:0] csr_wdata
);

   localparam int CW = tcfc_pkg::CYC_W;
   localparam int NW = tcfc_pkg::DIVIDEND_W;
   localparam int DW = tcfc_pkg::DIVISOR_W;
   localparam int SW = tcfc_pkg::STEP_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [tcfc_pkg::WARMUP_W-1:0]  warmup_ff, warmup_in;
   logic [tcfc_pkg::WINDOW_W-1:0]  window_ff, window_in;
   logic [tcfc_pkg::PERIOD_W-1:0]  period_ff, period_in;
   logic [TICK_WIDTH-1:0]          tick_ff, tick_in;
   logic [TICK_WIDTH-1:0]          start_tick_ff, start_tick_in;
   logic [CW-1:0]                  start_stamp_ff, start_stamp_in;
   logic [CW-1:0]                  stamp_ff, stamp_in;
   logic                           done_ff, done_in;
   logic [CW-1:0]                  held_cycles_ff, held_cycles_in;
   logic [CW-1:0]                  held_freq_ff, held_freq_in;
   logic [CW-1:0]                  cpt_ff, cpt_in;
   logic [NW-1:0]                  prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_cal_ff, rsp_cal_in;
   logic [CW-1:0]                  rsp_cycles_ff, rsp_cycles_in;
   logic [CW-1:0]                  rsp_freq_ff, rsp_freq_in;

   logic [TICK_WIDTH-1:0]          dt;
   logic [CW-1:0]                  dc;
   logic [CW-1:0]                  quot_lo;
   logic                           freq_sat;
   tcfc_pkg::div_req_type          div_req;
   tcfc_pkg::div_rsp_type          div_rsp;

   tcfc_div u_div (
      .clock (clock),
      .reset (reset),
      .req_i (div_req),
      .rsp_o (div_rsp)
   );

   always_comb begin
      dt       = tick_ff - start_tick_ff;
      dc       = stamp_ff - start_stamp_ff;
      quot_lo  = div_rsp.quotient[CW-1:0];
      // a zero period or a quotient beyond 64 bits saturates
      freq_sat = (period_ff == '0) || (div_rsp.quotient[NW-1:CW] != '0);

      state_in       = state_ff;
      warmup_in      = warmup_ff;
      window_in      = window_ff;
      period_in      = period_ff;
      tick_in        = tick_ff;
      start_tick_in  = start_tick_ff;
      start_stamp_in = start_stamp_ff;
      stamp_in       = stamp_ff;
      done_in        = done_ff;
      held_cycles_in = held_cycles_ff;
      held_freq_in   = held_freq_ff;
      cpt_in         = cpt_ff;
      prod_in        = prod_ff;
      rsp_cal_in     = rsp_cal_ff;
      rsp_cycles_in  = rsp_cycles_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;

      div_req.start    = 1'b0;
      div_req.dividend = NW'(dc) << tcfc_pkg::CPT_SHIFT;
      div_req.divisor  = DW'(dt);
      div_req.steps    = SW'(tcfc_pkg::STEPS_CPT);

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               tick_in  = tick_ff + TICK_WIDTH'(1);
               stamp_in = req_if.stamp;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (done_ff) begin
               state_in = ST_EMIT;
            end else if (start_tick_ff == '0) begin
               // start point is taken at the first tick past warmup
               if (tick_ff > TICK_WIDTH'(warmup_ff)) begin
                  start_tick_in  = tick_ff;
                  start_stamp_in = stamp_ff;
               end
               state_in = ST_EMIT;
            end else if (dt < TICK_WIDTH'(window_ff) || dt == '0 || dc == '0) begin
               state_in = ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               if (quot_lo == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  cpt_in   = quot_lo;
                  prod_in  = (NW'(quot_lo) << tcfc_pkg::MUL_SH_A)
                           - (NW'(quot_lo) << tcfc_pkg::MUL_SH_B);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // finish the times-1000 product and start the frequency divide
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff - (NW'(cpt_ff) << tcfc_pkg::MUL_SH_C);
            div_req.divisor  = DW'(period_ff);
            div_req.steps    = SW'(tcfc_pkg::STEPS_FREQ);
            state_in         = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               held_cycles_in = cpt_ff;
               held_freq_in   = freq_sat ? '1 : quot_lo;
               done_in        = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output slot is free, then load it
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cal_in    = done_ff;
               rsp_cycles_in = held_cycles_ff;
               rsp_freq_in   = held_freq_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            tcfc_pkg::CFG_WARMUP: warmup_in = csr_wdata[tcfc_pkg::WARMUP_W-1:0];
            tcfc_pkg::CFG_WINDOW: window_in = csr_wdata[tcfc_pkg::WINDOW_W-1:0];
            tcfc_pkg::CFG_PERIOD: period_in = csr_wdata[tcfc_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff      <= stamp_in;
      cpt_ff        <= cpt_in;
      prod_ff       <= prod_in;
      rsp_cal_ff    <= rsp_cal_in;
      rsp_cycles_ff <= rsp_cycles_in;
      rsp_freq_ff   <= rsp_freq_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         warmup_ff      <= tcfc_pkg::WARMUP_RESET;
         window_ff      <= tcfc_pkg::WINDOW_RESET;
         period_ff      <= tcfc_pkg::PERIOD_RESET;
         tick_ff        <= '0;
         start_tick_ff  <= '0;
         start_stamp_ff <= '0;
         done_ff        <= 1'b0;
         held_cycles_ff <= '0;
         held_freq_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         warmup_ff      <= warmup_in;
         window_ff      <= window_in;
         period_ff      <= period_in;
         tick_ff        <= tick_in;
         start_tick_ff  <= start_tick_in;
         start_stamp_ff <= start_stamp_in;
         done_ff        <= done_in;
         held_cycles_ff <= held_cycles_in;
         held_freq_ff   <= held_freq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.calibrated      = rsp_cal_ff;
   assign rsp_if.cycles_per_tick = rsp_cycles_ff;
   assign rsp_if.frequency_hz    = rsp_freq_ff;

endmodule

/* sv/tcfc_checker.sv */
// Port-level checker for the tick clock frequency calibrator, with its bind.
// Depends on tcfc_pkg for widths; attaches to tick_clock_frequency_calibrator.
module tcfc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_calibrated,
   input logic [tcfc_pkg::CYC_W-1:0] rsp_cycles_per_tick,
   input logic [tcfc_pkg::CYC_W-1:0] rsp_frequency_hz
);

   logic       seen_cal_ff, seen_cal_in;
   logic [1:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   always_comb begin
      req_beat    = req_valid && req_ready;
      rsp_beat    = rsp_valid && rsp_ready;
      seen_cal_in = seen_cal_ff || (rsp_beat && rsp_calibrated);
      pending_in  = pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_cal_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         seen_cal_ff <= seen_cal_in;
         pending_ff  <= pending_in;
      end
   end

   // once calibrated, every later beat stays calibrated
   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_cal_ff |-> rsp_calibrated)
      else $error("calibrated dropped after a calibrated beat");

   a_uncal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_calibrated |->
         (rsp_cycles_per_tick == '0) && (rsp_frequency_hz == '0))
      else $error("nonzero result before calibration");

   a_cal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrated |-> rsp_cycles_per_tick != '0)
      else $error("calibrated beat with zero cycles per tick");

   // no response beat without an accepted tick behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response beat with no outstanding tick");

endmodule

bind tick_clock_frequency_calibrator tcfc_checker u_tcfc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_calibrated      (rsp_if.calibrated),
   .rsp_cycles_per_tick (rsp_if.cycles_per_tick),
   .rsp_frequency_hz    (rsp_if.frequency_hz)
);

/* sim/tick_clock_frequency_calibrator_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the tick clock frequency calibrator: directed ticks, then random phases.
// Depends on tcfc_pkg, the channel interfaces in tcfc_if and tick_clock_frequency_calibrator.
module tick_clock_frequency_calibrator_tb;

   localparam int TICK_W         = 32;
   localparam int CYC_W          = tcfc_pkg::CYC_W;
   localparam int CFG_IDX_W      = tcfc_pkg::CFG_IDX_W;
   localparam int CFG_DATA_W     = tcfc_pkg::CFG_DATA_W;
   localparam int WARMUP_W       = tcfc_pkg::WARMUP_W;
   localparam int WINDOW_W       = tcfc_pkg::WINDOW_W;
   localparam int PERIOD_W       = tcfc_pkg::PERIOD_W;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int TAIL_CYCLES    = 200;   // longer than the slowest (measuring) tick
   localparam int TICK_TARGET    = 400;
   localparam int SQUEEZE_CYCLES = 300;

   // The register port decodes index 3 to nothing; writes there must be dropped.
   localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
   localparam logic [CYC_W-1:0] ALL_ONES = '1;
   localparam logic [CYC_W-1:0] FIRST_MARK = 64'h0123_4567_89AB_CDEF;

   typedef struct packed {
      logic             calibrated;
      logic [CYC_W-1:0] cycles_per_tick;
      logic [CYC_W-1:0] frequency_hz;
   } reading_type;

   typedef struct packed {
      logic        has_want;
      reading_type want;
   } typed_want_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CFG_IDX_W-1:0]  index;
      logic [CFG_DATA_W-1:0] wdata;
      logic [CYC_W-1:0]      stamp;
      logic                  has_want;
      reading_type           want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_wdata;

   tcfc_req_if req_bus ();
   tcfc_rsp_if rsp_bus ();

   tick_clock_frequency_calibrator #(
      .TICK_WIDTH(TICK_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Calibration predictor: its own copy of registers and measurement state
   // ---------------------------------------------------------------------
   logic [WARMUP_W-1:0] warmup_reg;
   logic [WINDOW_W-1:0] window_reg;
   logic [PERIOD_W-1:0] period_reg;
   logic [TICK_W-1:0]   tick_cnt;
   logic [TICK_W-1:0]   start_tick;    // zero while no start point is recorded
   logic [CYC_W-1:0]    start_stamp;
   logic                locked;
   logic [CYC_W-1:0]    held_cpt;
   logic [CYC_W-1:0]    held_freq;

   reading_type    pending_readings[$];   // expected response beats, oldest first
   typed_want_type typed_rows[$];         // hand-typed expectations of the directed rows
   plan_row_type   plan[$];

   int  mismatch_count = 0;
   int  ticks_sent = 0;
   int  burst_left = 0;
   bit  steady = 0;
   bit  squeeze_armed = 0;
   bit  squeezed = 0;

   // floor(cpt * 1000 / period), saturated; a zero period saturates too.
   function automatic logic [CYC_W-1:0] scale_to_hz(logic [CYC_W-1:0] cpt,
                                                    logic [PERIOD_W-1:0] period);
      logic [79:0] scaled;
      logic [79:0] quot;
      if (period == '0)
         return ALL_ONES;
      scaled = {16'd0, cpt} * 80'd1000;
      quot = scaled / {70'd0, period};
      return (quot[79:64] != '0) ? ALL_ONES : quot[63:0];
   endfunction

   // Advance the predictor by one reference tick and return the reading it leaves.
   function automatic reading_type advance_calibration(logic [CYC_W-1:0] stamp);
      logic [TICK_W-1:0] dt;
      logic [CYC_W-1:0]  dc;
      logic [CYC_W-1:0]  cpt;
      tick_cnt = tick_cnt + TICK_W'(1);
      if (!locked) begin
         if (start_tick == '0) begin
            if (tick_cnt > TICK_W'(warmup_reg)) begin
               start_tick  = tick_cnt;
               start_stamp = stamp;
            end
         end else begin
            dt = tick_cnt - start_tick;
            dc = stamp - start_stamp;
            // a short window, a zero tick delta or no elapsed cycles: retry next tick
            if (dt >= TICK_W'(window_reg) && dt != '0 && dc != '0) begin
               cpt = dc / CYC_W'(dt);
               if (cpt != '0) begin
                  held_cpt  = cpt;
                  held_freq = scale_to_hz(cpt, period_reg);
                  locked    = 1'b1;
               end
            end
         end
      end
      return '{locked, held_cpt, held_freq};
   endfunction

   // Stamp for the next tick that keeps the block measuring without locking:
   // no elapsed cycles, or fewer cycles than ticks so the quotient is zero.
   // Outside the measuring window a stamp cannot lock the block, so send noise there.
   function automatic logic [CYC_W-1:0] quiet_stamp();
      logic [TICK_W-1:0] next_dt;
      next_dt = tick_cnt + TICK_W'(1) - start_tick;
      if (locked || start_tick == '0 || next_dt < TICK_W'(window_reg) || next_dt == '0)
         return {$urandom, $urandom};
      if (next_dt < TICK_W'(2) || $urandom_range(0, 2) == 0)
         return start_stamp;
      return start_stamp + CYC_W'($urandom_range(1, next_dt - TICK_W'(1)));
   endfunction

   // Stamp for the next tick that should lock: modest rates, random spans and
   // spans close to a full counter wrap (large rates that saturate the frequency).
   function automatic logic [CYC_W-1:0] locking_stamp();
      logic [TICK_W-1:0] next_dt;
      logic [CYC_W-1:0]  span;
      next_dt = tick_cnt + TICK_W'(1) - start_tick;
      case ($urandom_range(0, 2))
         0: span = CYC_W'(next_dt) * CYC_W'($urandom_range(1, 5000))
                 + CYC_W'($urandom_range(0, next_dt - TICK_W'(1)));
         1: span = {$urandom, $urandom};
         default: span = ALL_ONES - CYC_W'($urandom_range(0, 255));
      endcase
      return start_stamp + span;
   endfunction

   function automatic plan_row_type tick_row(logic [CYC_W-1:0] stamp);
      return '{ROW_TICK, CFG_SPARE, '0, stamp, 1'b1, '0};
   endfunction

   function automatic plan_row_type write_row(logic [CFG_IDX_W-1:0] index,
                                              logic [CFG_DATA_W-1:0] value);
      return '{ROW_WRITE, index, value, '0, 1'b0, '0};
   endfunction

   // Append one row to the directed plan.
   function automatic void add_row(plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset, watchdog
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Monitor: mirror register writes, predict accepted ticks, check responses
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      reading_type    want;
      reading_type    got;
      typed_want_type row_want;
      if (reset) begin
         warmup_reg  = tcfc_pkg::WARMUP_RESET;
         window_reg  = tcfc_pkg::WINDOW_RESET;
         period_reg  = tcfc_pkg::PERIOD_RESET;
         tick_cnt    = '0;
         start_tick  = '0;
         start_stamp = '0;
         locked      = 1'b0;
         held_cpt    = '0;
         held_freq   = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tcfc_pkg::CFG_WARMUP: warmup_reg = csr_wdata[WARMUP_W-1:0];
               tcfc_pkg::CFG_WINDOW: window_reg = csr_wdata[WINDOW_W-1:0];
               tcfc_pkg::CFG_PERIOD: period_reg = csr_wdata[PERIOD_W-1:0];
               default: ;   // drop writes to undecoded indexes
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            want = advance_calibration(req_bus.stamp);
            // directed rows carry their own typed expectation
            if (typed_rows.size() != 0) begin
               row_want = typed_rows.pop_front();
               if (row_want.has_want)
                  want = row_want.want;
            end
            pending_readings.insert(pending_readings.size(), want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.calibrated, rsp_bus.cycles_per_tick, rsp_bus.frequency_hz};
            if (pending_readings.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response beat, got %h / %h / %h", $time,
                        got.calibrated, got.cycles_per_tick, got.frequency_hz);
            end else begin
               want = pending_readings.pop_front();
               if (got.calibrated !== want.calibrated) begin
                  mismatch_count++;
                  $display("%0t: calibrated expected %h got %h", $time,
                           want.calibrated, got.calibrated);
               end
               if (got.cycles_per_tick !== want.cycles_per_tick) begin
                  mismatch_count++;
                  $display("%0t: cycles_per_tick expected %h got %h", $time,
                           want.cycles_per_tick, got.cycles_per_tick);
               end
               if (got.frequency_hz !== want.frequency_hz) begin
                  mismatch_count++;
                  $display("%0t: frequency_hz expected %h got %h", $time,
                           want.frequency_hz, got.frequency_hz);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall on a pattern of its own, plus one long hold-off
   // ---------------------------------------------------------------------
   initial begin : receiver
      int mode;
      int span;
      mode = 0;
      span = 0;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (squeeze_armed && !squeezed) begin
            // hold off long enough for the block to fill and stall its input
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
            squeezed = 1'b1;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 2);
               span = $urandom_range(20, 80);
            end
            span--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender helpers (called at a falling edge, return at a falling edge)
   // ---------------------------------------------------------------------

   // Offer one tick, opening a new burst after a random gap when the last one ran out.
   task automatic offer_tick(logic [CYC_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 24);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.stamp <= stamp;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Drop valid and wait for every outstanding response; the block is idle after.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0)
         @(negedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after its last write.
   task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type row;
      int           attempts;

      req_bus.valid = 1'b0;
      req_bus.stamp = '0;
      csr_we        = 1'b0;
      csr_index     = tcfc_pkg::CFG_WARMUP;
      csr_wdata     = '0;
      reset         = 1'b1;

      // Directed plan. Every tick here leaves the block uncalibrated, so the
      // expected beat is all zeros throughout.
      // Warmup at its reset value: the first four ticks only count, also
      // carrying the stamp extremes and both alternating patterns.
      add_row(tick_row(64'h0));
      add_row(tick_row(ALL_ONES));
      add_row(tick_row(64'h5555_5555_5555_5555));
      add_row(tick_row(64'hAAAA_AAAA_AAAA_AAAA));
      // fifth tick passes warmup and records the start point
      add_row(tick_row(FIRST_MARK));
      // shrink the window so the following ticks actually measure
      add_row(write_row(tcfc_pkg::CFG_WINDOW, 16'd1));
      add_row(write_row(CFG_SPARE, 16'hFFFF));
      // no elapsed cycles: ignored, retried next tick
      add_row(tick_row(FIRST_MARK));
      add_row(tick_row(FIRST_MARK));
      // fewer cycles than ticks: zero quotient, ignored
      add_row(tick_row(FIRST_MARK + 64'd1));
      // zero window: measure on every tick, never divide by zero
      add_row(write_row(tcfc_pkg::CFG_WINDOW, 16'd0));
      add_row(tick_row(FIRST_MARK + 64'd3));
      add_row(tick_row(FIRST_MARK));
      // warmup extremes once the start point exists: no effect
      add_row(write_row(tcfc_pkg::CFG_WARMUP, 16'h00FF));
      add_row(tick_row(FIRST_MARK + 64'd2));
      add_row(write_row(tcfc_pkg::CFG_WARMUP, 16'h0000));
      add_row(tick_row(FIRST_MARK + 64'd5));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed plan; register writes only once the block is idle.
      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            write_reg(row.index, row.wdata);
         end else begin
            csr_we <= 1'b0;
            typed_rows.insert(typed_rows.size(), '{row.has_want, row.want});
            offer_tick(row.stamp);
         end
      end
      csr_we <= 1'b0;

      // Squeeze: a huge window makes ticks fast; offer them back to back while
      // the receiver holds off, so the output slot fills and the input stalls.
      settle();
      write_reg(tcfc_pkg::CFG_WINDOW, 16'hFFFF);
      csr_we <= 1'b0;
      squeeze_armed = 1'b1;
      steady = 1'b1;
      repeat (24) offer_tick(quiet_stamp());
      steady = 1'b0;

      // Random phases: pause until idle, reprogram, then a run of ticks that
      // keep the block measuring without locking (noise where it is not measuring).
      while (ticks_sent < TICK_TARGET - 40) begin
         settle();
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
               0: write_reg(tcfc_pkg::CFG_WARMUP, 16'd0);
               1: write_reg(tcfc_pkg::CFG_WARMUP, 16'd255);
               default: write_reg(tcfc_pkg::CFG_WARMUP, 16'($urandom));
            endcase
         end
         case ($urandom_range(0, 6))
            0: write_reg(tcfc_pkg::CFG_WINDOW, 16'd0);
            1: write_reg(tcfc_pkg::CFG_WINDOW, 16'd1);
            2: write_reg(tcfc_pkg::CFG_WINDOW, 16'hFFFF);
            3: write_reg(tcfc_pkg::CFG_WINDOW, 16'($urandom));
            default: write_reg(tcfc_pkg::CFG_WINDOW, 16'($urandom_range(0, 300)));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0: write_reg(tcfc_pkg::CFG_PERIOD, 16'd0);
               1: write_reg(tcfc_pkg::CFG_PERIOD, 16'd1);
               2: write_reg(tcfc_pkg::CFG_PERIOD, 16'd1000);
               3: write_reg(tcfc_pkg::CFG_PERIOD, 16'h03FF);
               4: write_reg(tcfc_pkg::CFG_PERIOD, 16'($urandom_range(1, 1000)));
               default: write_reg(tcfc_pkg::CFG_PERIOD, 16'($urandom));
            endcase
         end
         if ($urandom_range(0, 5) == 0)
            write_reg(CFG_SPARE, 16'($urandom));
         csr_we <= 1'b0;
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(8, 40)) offer_tick(quiet_stamp());
         steady = 1'b0;
      end

      // Lock: a tiny window and a period drawn from its extremes, its reset value
      // or at random, then ticks whose elapsed cycles give a nonzero quotient.
      settle();
      write_reg(tcfc_pkg::CFG_WINDOW, 16'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
         0: write_reg(tcfc_pkg::CFG_PERIOD, 16'd0);
         1: write_reg(tcfc_pkg::CFG_PERIOD, 16'd1);
         2: write_reg(tcfc_pkg::CFG_PERIOD, 16'd55);
         3: write_reg(tcfc_pkg::CFG_PERIOD, 16'd1000);
         4: write_reg(tcfc_pkg::CFG_PERIOD, 16'h03FF);
         default: write_reg(tcfc_pkg::CFG_PERIOD, 16'($urandom_range(1, 1000)));
      endcase
      csr_we <= 1'b0;
      attempts = 0;
      while (!locked && attempts < 64) begin
         offer_tick(locking_stamp());
         attempts++;
      end

      // After locking, register writes and any stamp must leave the reading held.
      settle();
      write_reg(tcfc_pkg::CFG_WARMUP, 16'($urandom));
      write_reg(tcfc_pkg::CFG_WINDOW, 16'($urandom));
      write_reg(tcfc_pkg::CFG_PERIOD, 16'($urandom));
      write_reg(CFG_SPARE, 16'($urandom));
      csr_we <= 1'b0;
      repeat (30) offer_tick({$urandom, $urandom});

      // Drain, then idle long enough to catch any stray response beat.
      settle();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
